// File: design/thtbl_pkg.sv
// Shared constants, types and helper functions of the tiered handle table.
package thtbl_pkg;

    localparam int SLOT_BITS     = 2;
    localparam int FANOUT_BITS   = 2;
    localparam int LEVEL_BITS    = 2;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int TAG_WIDTH     = 8;

    localparam int NUM_TIERS    = 1 << LEVEL_BITS;
    localparam int LEVEL_SHIFT  = ((1 << LEVEL_BITS) - 1) * FANOUT_BITS + SLOT_BITS;
    localparam int HANDLE_WIDTH = LEVEL_SHIFT + LEVEL_BITS;
    localparam int REQ_WIDTH    = 2;
    localparam int STATUS_WIDTH = 3;

    function automatic int tier_size(input int t);
        return 1 << (SLOT_BITS + t * FANOUT_BITS);
    endfunction

    function automatic int tier_base(input int t);
        int base;
        base = 0;
        for (int i = 0; i < t; i++)
        begin
            base = base + tier_size(i);
        end
        return base;
    endfunction

    localparam int TOTAL_ENTRIES = tier_base(NUM_TIERS);
    localparam int POS_W         = $clog2(TOTAL_ENTRIES);

    // The allocation bitmap is kept as words; a flat position is {word, bit}.
    localparam int WORD_SEL_W = 4;
    localparam int WORD_BITS  = 1 << WORD_SEL_W;
    localparam int NUM_WORDS  = (TOTAL_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = $clog2(NUM_WORDS);
    localparam int FLAT_W     = WADDR_W + WORD_SEL_W;

    // Width of the shared find-first-zero unit.
    localparam int FF_W     = (NUM_WORDS > WORD_BITS) ? NUM_WORDS : WORD_BITS;
    localparam int FF_IDX_W = $clog2(FF_W);

    localparam logic [TAG_WIDTH-1:0] TAG_EMPTY = TAG_WIDTH'(0);
    localparam logic [TAG_WIDTH-1:0] TAG_LINK  = TAG_WIDTH'(1);

    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_INSERT = 2'd0,
        REQ_GET    = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NONE   = 2'd3
    } req_kind_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK        = 3'd0,
        ST_RESERVED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_NULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_MISMATCH  = 3'd5
    } status_t;

    typedef struct packed {
        logic                found;
        logic [FF_IDX_W-1:0] idx;
    } ffz_res_t;

endpackage

// File: design/thtbl_req_if.sv
// Request channel of the tiered handle table.
interface thtbl_req_if;
    import thtbl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_WIDTH-1:0]    req_type;
    logic [HANDLE_WIDTH-1:0] handle_in;
    logic [TAG_WIDTH-1:0]    tag_in;
    logic [PAYLOAD_WIDTH-1:0] object_in;

    modport source (output valid, output req_type, output handle_in, output tag_in,
                    output object_in, input ready);
    modport sink (input valid, input req_type, input handle_in, input tag_in,
                  input object_in, output ready);
endinterface

// File: design/thtbl_rsp_if.sv
// Response channel of the tiered handle table.
interface thtbl_rsp_if;
    import thtbl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_WIDTH-1:0]  status;
    logic [HANDLE_WIDTH-1:0]  handle_out;
    logic [PAYLOAD_WIDTH-1:0] object_out;

    modport source (output valid, output status, output handle_out, output object_out,
                    input ready);
    modport sink (input valid, input status, input handle_out, input object_out,
                  output ready);
endinterface

// File: design/thtbl_ffz.sv
// Shared find-first-zero unit used for both the word summary and a bitmap word.
module thtbl_ffz (
    input  logic [thtbl_pkg::FF_W-1:0] vec,
    output thtbl_pkg::ffz_res_t        res
);
    import thtbl_pkg::*;

    // Scanning downward leaves the lowest zero position as the winner.
    always_comb
    begin
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = FF_W - 1; i >= 0; i--)
        begin
            if (!vec[i])
            begin
                res.found = 1'b1;
                res.idx   = FF_IDX_W'(i);
            end
        end
    end
endmodule

// File: design/tiered_handle_table_core.sv
// Top level of the tiered handle table: sequencer, bitmap, entry store and result register.
//
//  channel | dir | handshake     | beat carries
//  --------+-----+---------------+------------------------------------------
//  req     | in  | valid / ready | req_type, handle_in, tag_in, object_in
//  rsp     | out | valid / ready | status, handle_out, object_out
//
// Insert passes the scan, word and response steps before its result is loaded; it
// runs the find-first-zero unit twice (word summary, then one bitmap word). Get and
// delete pass the look, check and response steps, with the registered store read in look.
// Reserved tags and unused request kinds go straight to response; null handles skip check.
// Reset clears only the bitmap and its summary; no clearing pass is needed.
// A result waits in the output register; the next beat is taken meanwhile, but a
// second result stalls the sequencer until rsp accepts the first.
module tiered_handle_table_core (
    input  logic        clk,
    input  logic        rst_n,
    thtbl_req_if.sink   req,
    thtbl_rsp_if.source rsp
);
    import thtbl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_WORD  = 6'b000100,
        S_LOOK  = 6'b001000,
        S_CHECK = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    // Positions past the last entry in the last word read as allocated.
    function automatic logic [WORD_BITS-1:0] word_pad(input logic [WADDR_W-1:0] w);
        logic [WORD_BITS-1:0] m;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            m[b] = ({w, WORD_SEL_W'(b)} >= FLAT_W'(TOTAL_ENTRIES));
        end
        return m;
    endfunction

    state_t state_reg, state_next;

    logic [WORD_BITS-1:0] words_reg [NUM_WORDS];
    logic [WORD_BITS-1:0] words_next [NUM_WORDS];
    logic [NUM_WORDS-1:0] full_reg, full_next;

    req_kind_t                kind_reg;
    logic [HANDLE_WIDTH-1:0]  handle_reg;
    logic [TAG_WIDTH-1:0]     tag_reg;
    logic [PAYLOAD_WIDTH-1:0] obj_reg;

    logic [WADDR_W-1:0] word_reg, word_next;
    logic [FLAT_W-1:0]  pos_reg, pos_next;
    logic               hit_reg, hit_next;

    status_t                  res_status_reg, res_status_next;
    logic [HANDLE_WIDTH-1:0]  res_handle_reg, res_handle_next;
    logic [PAYLOAD_WIDTH-1:0] res_object_reg, res_object_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg;
    logic [HANDLE_WIDTH-1:0]  out_handle_reg;
    logic [PAYLOAD_WIDTH-1:0] out_object_reg;

    logic [TAG_WIDTH+PAYLOAD_WIDTH-1:0] store_mem [TOTAL_ENTRIES];
    logic [TAG_WIDTH+PAYLOAD_WIDTH-1:0] rd_data_reg;
    logic                               mem_we;
    logic [POS_W-1:0]                   mem_addr;

    logic                acc;
    logic                load_out;
    logic [FF_W-1:0]     ffz_vec;
    ffz_res_t            ffz_res;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] new_bit;
    logic [FLAT_W-1:0]   new_pos;
    logic [FLAT_W-1:0]   new_idx;
    logic [LEVEL_BITS-1:0] new_tier;
    logic [HANDLE_WIDTH-1:0] new_handle;
    logic [FLAT_W-1:0]   look_pos;
    logic [TAG_WIDTH-1:0] rd_tag;
    logic [PAYLOAD_WIDTH-1:0] rd_obj;

    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.handle_out = out_handle_reg;
    assign rsp.object_out = out_object_reg;

    assign rd_tag = rd_data_reg[PAYLOAD_WIDTH +: TAG_WIDTH];
    assign rd_obj = rd_data_reg[PAYLOAD_WIDTH-1:0];

    // The shared unit looks at the word summary while scanning, then at one word.
    assign cur_word = words_reg[word_reg] | word_pad(word_reg);

    always_comb
    begin
        ffz_vec = '1;
        if (state_reg == S_SCAN)
        begin
            ffz_vec[NUM_WORDS-1:0] = full_reg;
        end
        else
        begin
            ffz_vec[WORD_BITS-1:0] = cur_word;
        end
    end

    thtbl_ffz u_ffz (
        .vec (ffz_vec),
        .res (ffz_res)
    );

    assign new_pos = {word_reg, ffz_res.idx[WORD_SEL_W-1:0]};
    assign new_bit = WORD_BITS'(1) << ffz_res.idx[WORD_SEL_W-1:0];

    // Flat position back to tier and index within the tier.
    always_comb
    begin
        new_tier = '0;
        new_idx  = new_pos;
        for (int t = 0; t < NUM_TIERS; t++)
        begin
            if (new_pos >= FLAT_W'(tier_base(t)))
            begin
                new_tier = LEVEL_BITS'(t);
                new_idx  = new_pos - FLAT_W'(tier_base(t));
            end
        end
        new_handle = {new_tier, new_idx[LEVEL_SHIFT-1:0]};
    end

    // Handle to flat position; index bits above the tier's width are dropped.
    always_comb
    begin
        look_pos = '0;
        for (int t = 0; t < NUM_TIERS; t++)
        begin
            if (handle_reg[HANDLE_WIDTH-1 -: LEVEL_BITS] == LEVEL_BITS'(t))
            begin
                look_pos = FLAT_W'(tier_base(t))
                         + FLAT_W'(handle_reg[LEVEL_SHIFT-1:0]
                                   & LEVEL_SHIFT'(tier_size(t) - 1));
            end
        end
    end

    assign mem_we   = (state_reg == S_WORD);
    assign mem_addr = (state_reg == S_WORD) ? new_pos[POS_W-1:0] : look_pos[POS_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        words_next      = words_reg;
        full_next       = full_reg;
        word_next       = word_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_object_next = res_object_reg;
        load_out        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    res_status_next = ST_OK;
                    res_handle_next = '0;
                    res_object_next = '0;
                    case (req_kind_t'(req.req_type))
                        REQ_INSERT:
                        begin
                            if (req.tag_in == TAG_EMPTY || req.tag_in == TAG_LINK)
                            begin
                                res_status_next = ST_RESERVED;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_GET, REQ_DELETE:
                        begin
                            state_next = S_LOOK;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (ffz_res.found)
                begin
                    word_next  = ffz_res.idx[WADDR_W-1:0];
                    state_next = S_WORD;
                end
                else
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_RESP;
                end
            end
            S_WORD:
            begin
                words_next[word_reg] = words_reg[word_reg] | new_bit;
                full_next[word_reg]  = &(cur_word | new_bit);
                res_handle_next      = new_handle;
                state_next           = S_RESP;
            end
            S_LOOK:
            begin
                pos_next = look_pos;
                hit_next = words_reg[look_pos[FLAT_W-1 -: WADDR_W]][look_pos[WORD_SEL_W-1:0]];
                if (handle_reg == '0)
                begin
                    res_status_next = ST_NULL;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // The reserved first entry is allocated but holds no tag.
                if (!hit_reg || pos_reg == '0)
                begin
                    res_status_next = ST_NOT_FOUND;
                end
                else if (kind_reg == REQ_GET)
                begin
                    if (rd_tag != tag_reg)
                    begin
                        res_status_next = ST_MISMATCH;
                    end
                    else
                    begin
                        res_object_next = rd_obj;
                    end
                end
                else
                begin
                    words_next[pos_reg[FLAT_W-1 -: WADDR_W]][pos_reg[WORD_SEL_W-1:0]] = 1'b0;
                    full_next[pos_reg[FLAT_W-1 -: WADDR_W]] = 1'b0;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            full_reg      <= '0;
            // Entry zero of the first tier starts out allocated.
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                words_reg[w] <= (w == 0) ? WORD_BITS'(1) : WORD_BITS'(0);
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            full_reg      <= full_next;
            words_reg     <= words_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            kind_reg   <= req_kind_t'(req.req_type);
            handle_reg <= req.handle_in;
            tag_reg    <= req.tag_in;
            obj_reg    <= req.object_in;
        end
        word_reg       <= word_next;
        pos_reg        <= pos_next;
        hit_reg        <= hit_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_object_reg <= res_object_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_object_reg <= res_object_reg;
        end
    end

    // Entry store: tag and payload, valid only where the bitmap says allocated.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= {tag_reg, obj_reg};
        end
        rd_data_reg <= store_mem[mem_addr];
    end

    a_entry0_kept: assert property (@(posedge clk) disable iff (!rst_n)
        words_reg[0][0])
        else $error("reserved first entry was freed");

    a_word_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WORD |-> ffz_res.found)
        else $error("selected bitmap word has no free bit");

    a_word_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WORD |-> !full_reg[word_reg])
        else $error("scan selected a word marked full");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("sequencer did not start on an accepted beat");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !$past(rsp.valid) |-> $past(state_reg == S_RESP))
        else $error("result appeared outside the response step");

endmodule

// File: tb/sv/tb_tiered_handle_table_core.sv
// Self-checking testbench of the tiered handle table core, with its scoreboard class.
module tb_tiered_handle_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import thtbl_pkg::*;

    typedef struct {
        status_t                  status;
        logic [HANDLE_WIDTH-1:0]  handle;
        logic [PAYLOAD_WIDTH-1:0] object;
    } table_result_t;

    // Tracks the allocation bitmap and the entry store as the block should see them,
    // and keeps the answers still owed by the block in request order.
    class handle_table_scoreboard;
        bit                       used [TOTAL_ENTRIES];
        logic [TAG_WIDTH-1:0]     tags [TOTAL_ENTRIES];
        logic [PAYLOAD_WIDTH-1:0] payloads [TOTAL_ENTRIES];
        int                       tier_first [NUM_TIERS];
        int                       tier_len [NUM_TIERS];
        table_result_t            owed_results [$];
        int                       errors;
        int                       checked;
        int                       status_seen [6];

        function new();
            int first;
            first = 0;
            for (int t = 0; t < NUM_TIERS; t++)
            begin
                tier_len[t]   = 1 << (SLOT_BITS + t * FANOUT_BITS);
                tier_first[t] = first;
                first         = first + tier_len[t];
            end
            foreach (used[i])
            begin
                used[i]     = 1'b0;
                tags[i]     = TAG_EMPTY;
                payloads[i] = '0;
            end
            // Entry zero of the first tier stays allocated forever.
            used[0] = 1'b1;
            errors  = 0;
            checked = 0;
            foreach (status_seen[i])
            begin
                status_seen[i] = 0;
            end
        endfunction

        function logic [HANDLE_WIDTH-1:0] entry_handle(int pos);
            logic [HANDLE_WIDTH-1:0] h;
            h = '0;
            for (int t = 0; t < NUM_TIERS; t++)
            begin
                if (pos >= tier_first[t] && pos < tier_first[t] + tier_len[t])
                begin
                    h = HANDLE_WIDTH'((t << LEVEL_SHIFT) | (pos - tier_first[t]));
                end
            end
            return h;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function bit pick_live(output logic [HANDLE_WIDTH-1:0] h,
                               output logic [TAG_WIDTH-1:0] tag);
            int live [$];
            int pos;
            h   = '0;
            tag = TAG_EMPTY;
            foreach (tags[i])
            begin
                if (tags[i] != TAG_EMPTY)
                begin
                    live.push_back(i);
                end
            end
            if (live.size() == 0)
            begin
                return 1'b0;
            end
            pos = live[$urandom_range(0, live.size() - 1)];
            h   = entry_handle(pos);
            tag = tags[pos];
            return 1'b1;
        endfunction

        function void note_request(req_kind_t kind, logic [HANDLE_WIDTH-1:0] h,
                                   logic [TAG_WIDTH-1:0] tag, logic [PAYLOAD_WIDTH-1:0] obj);
            table_result_t r;
            int            pos;
            int            tier;
            r.status = ST_OK;
            r.handle = '0;
            r.object = '0;
            case (kind)
                REQ_INSERT:
                begin
                    if (tag == TAG_EMPTY || tag == TAG_LINK)
                    begin
                        r.status = ST_RESERVED;
                    end
                    else
                    begin
                        // Flat order runs tier by tier, lowest index first.
                        pos = -1;
                        for (int i = 0; i < TOTAL_ENTRIES && pos < 0; i++)
                        begin
                            if (!used[i])
                            begin
                                pos = i;
                            end
                        end
                        if (pos < 0)
                        begin
                            r.status = ST_FULL;
                        end
                        else
                        begin
                            used[pos]     = 1'b1;
                            tags[pos]     = tag;
                            payloads[pos] = obj;
                            r.handle      = entry_handle(pos);
                        end
                    end
                end
                REQ_GET, REQ_DELETE:
                begin
                    if (h == '0)
                    begin
                        r.status = ST_NULL;
                    end
                    else
                    begin
                        // Index bits above the tier's width are dropped.
                        tier = int'(h[HANDLE_WIDTH-1:LEVEL_SHIFT]);
                        pos  = tier_first[tier] + (int'(h[LEVEL_SHIFT-1:0]) & (tier_len[tier] - 1));
                        if (tags[pos] == TAG_EMPTY)
                        begin
                            r.status = ST_NOT_FOUND;
                        end
                        else if (kind == REQ_GET)
                        begin
                            if (tags[pos] != tag)
                            begin
                                r.status = ST_MISMATCH;
                            end
                            else
                            begin
                                r.object = payloads[pos];
                            end
                        end
                        else
                        begin
                            tags[pos]     = TAG_EMPTY;
                            payloads[pos] = '0;
                            used[pos]     = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_WIDTH-1:0] got_status,
                                   logic [HANDLE_WIDTH-1:0] got_handle,
                                   logic [PAYLOAD_WIDTH-1:0] got_object);
            table_result_t r;
            if (owed_results.size() == 0)
            begin
                $error("unexpected result beat: status %0d handle_out %h object_out %h",
                       got_status, got_handle, got_object);
                errors++;
                return;
            end
            r = owed_results.pop_front();
            checked++;
            status_seen[r.status]++;
            if (got_status !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, got_status);
                errors++;
            end
            if (got_handle !== r.handle)
            begin
                $error("handle_out: expected %h, actual %h", r.handle, got_handle);
                errors++;
            end
            if (got_object !== r.object)
            begin
                $error("object_out: expected %h, actual %h", r.object, got_object);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   src_calm;
    int   sent;

    handle_table_scoreboard table_sb;

    thtbl_req_if req_ch();
    thtbl_rsp_if rsp_ch();

    tiered_handle_table_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short pauses, now and then a long one.
    function int idle_length();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function logic [HANDLE_WIDTH-1:0] with_stray_bits(logic [HANDLE_WIDTH-1:0] h);
        int                     width;
        logic [LEVEL_SHIFT-1:0] extra;
        width = SLOT_BITS + int'(h[HANDLE_WIDTH-1:LEVEL_SHIFT]) * FANOUT_BITS;
        extra = LEVEL_SHIFT'($urandom) & ({LEVEL_SHIFT{1'b1}} << width);
        return h | HANDLE_WIDTH'(extra);
    endfunction

    task automatic send_request(req_kind_t kind, logic [HANDLE_WIDTH-1:0] h,
                                logic [TAG_WIDTH-1:0] tag, logic [PAYLOAD_WIDTH-1:0] obj);
        int gap;
        gap = (src_calm || $urandom_range(0, 99) < 50) ? 0 : idle_length();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.handle_in <= h;
        req_ch.tag_in    <= tag;
        req_ch.object_in <= obj;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        table_sb.note_request(kind, h, tag, obj);
        sent++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (table_sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(int count, int ins_w, int get_w, int del_w);
        int                      r;
        logic [HANDLE_WIDTH-1:0] h;
        logic [TAG_WIDTH-1:0]    tag;
        for (int i = 0; i < count; i++)
        begin
            if (i % 96 == 0)
            begin
                src_calm = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < ins_w)
            begin
                tag = ($urandom_range(0, 19) == 0) ? TAG_WIDTH'($urandom_range(0, 1))
                                                   : TAG_WIDTH'($urandom_range(2, 255));
                send_request(REQ_INSERT, HANDLE_WIDTH'($urandom), tag, $urandom);
            end
            else if (r < ins_w + get_w + del_w)
            begin
                if (!table_sb.pick_live(h, tag))
                begin
                    h   = HANDLE_WIDTH'($urandom);
                    tag = TAG_WIDTH'($urandom);
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    h = with_stray_bits(h);
                end
                if (r < ins_w + get_w)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        tag = tag ^ TAG_WIDTH'($urandom_range(1, 255));
                    end
                    send_request(REQ_GET, h, tag, $urandom);
                end
                else
                begin
                    send_request(REQ_DELETE, h, TAG_WIDTH'($urandom), $urandom);
                end
            end
            else
            begin
                send_request(req_kind_t'($urandom_range(0, 3)), HANDLE_WIDTH'($urandom),
                             TAG_WIDTH'($urandom), $urandom);
            end
        end
    endtask

    // Result side: check each accepted beat, then decide whether to stall.
    initial
    begin
        int  hold;
        int  cycles;
        bit  sink_calm;
        hold      = 0;
        cycles    = 0;
        sink_calm = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                table_sb.check_result(rsp_ch.status, rsp_ch.handle_out, rsp_ch.object_out);
            end
            cycles++;
            if (cycles % 400 == 0)
            begin
                sink_calm = ($urandom_range(0, 3) == 0);
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (sink_calm || $urandom_range(0, 99) < 70)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                hold = idle_length() - 1;
                rsp_ch.ready <= 1'b0;
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        table_sb = new();
        sent     = 0;
        src_calm = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_NONE;
        req_ch.handle_in = '0;
        req_ch.tag_in    = '0;
        req_ch.object_in = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Null handles, empty entries and the permanently reserved first entry.
        send_request(REQ_GET, 10'h000, 8'h02, 32'h0);
        send_request(REQ_DELETE, 10'h000, 8'h00, 32'h0);
        send_request(REQ_GET, 10'h004, 8'h00, 32'h0);
        send_request(REQ_DELETE, 10'h004, 8'h00, 32'h0);
        send_request(REQ_DELETE, 10'h3FF, 8'hFF, 32'hFFFF_FFFF);
        // Reserved tags are refused.
        send_request(REQ_INSERT, 10'h3FF, TAG_EMPTY, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 10'h000, TAG_LINK, 32'h1234_5678);
        // Fill the first tier and spill into the second.
        send_request(REQ_INSERT, 10'h000, 8'hFF, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 10'h3FF, 8'h02, 32'h0000_0000);
        send_request(REQ_INSERT, 10'h155, 8'h80, 32'hA5A5_5A5A);
        send_request(REQ_INSERT, 10'h2AA, 8'h7F, 32'h0000_0001);
        // Lookups: exact, with ignored high index bits, and with a wrong tag.
        send_request(REQ_GET, 10'h001, 8'hFF, 32'h0);
        send_request(REQ_GET, 10'h0FD, 8'hFF, 32'h0);
        send_request(REQ_GET, 10'h002, 8'h03, 32'h0);
        send_request(REQ_GET, 10'h002, 8'h02, 32'h0);
        send_request(REQ_NONE, 10'h3FF, 8'hFF, 32'hFFFF_FFFF);
        // Delete, then the freed entry is empty and gets reused.
        send_request(REQ_DELETE, 10'h002, 8'h00, 32'h0);
        send_request(REQ_GET, 10'h002, 8'h02, 32'h0);
        send_request(REQ_DELETE, 10'h002, 8'h00, 32'h0);
        send_request(REQ_INSERT, 10'h000, 8'h55, 32'h5555_AAAA);
        send_request(REQ_GET, 10'h100, 8'h7F, 32'h0);
        send_request(REQ_DELETE, 10'h1F0, 8'h00, 32'h0);
        send_request(REQ_GET, 10'h300, 8'h7F, 32'h0);
        drain_results();

        // Churn, fill past capacity, drain, churn again.
        run_phase(400, 40, 35, 20);
        drain_results();
        run_phase(500, 80, 10, 5);
        run_phase(400, 10, 20, 65);
        drain_results();
        run_phase(300, 40, 35, 20);

        drain_results();
        repeat (12) @(posedge clk);

        $display("Run covered %0d requests over %0d checked answers: %0d ok, %0d reserved tag,",
                 sent, table_sb.checked, table_sb.status_seen[ST_OK],
                 table_sb.status_seen[ST_RESERVED]);
        $display("%0d table full, %0d null handle, %0d not found, %0d tag mismatch.",
                 table_sb.status_seen[ST_FULL], table_sb.status_seen[ST_NULL],
                 table_sb.status_seen[ST_NOT_FOUND], table_sb.status_seen[ST_MISMATCH]);
        if (table_sb.errors == 0 && table_sb.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
